@@ design/idru_pkg.sv @@
// Shared constants, types and the one-bit division step of the integer divide unit.
package idru_pkg;

  // Operand and operation widths.
  localparam int unsigned DataWidth = 32;
  localparam int unsigned OpWidth   = 3;

  // Number of quotient bits that each pipeline stage resolves.
  localparam int unsigned DefaultBitsPerStage = 2;

  // Operation codes. The codes below these four select no operation and return zero.
  localparam logic [OpWidth-1:0] OpDiv  = 3'b100;
  localparam logic [OpWidth-1:0] OpDivu = 3'b101;
  localparam logic [OpWidth-1:0] OpRem  = 3'b110;
  localparam logic [OpWidth-1:0] OpRemu = 3'b111;

  // Fixed results for a signed and an unsigned divide by zero.
  localparam logic [DataWidth-1:0] DivZeroSigned   = 32'h7FFF_FFFF;
  localparam logic [DataWidth-1:0] DivZeroUnsigned = 32'hFFFF_FFFF;

  // Per-transaction control that travels down the pipeline with the data.
  typedef struct packed {
    logic is_rem;       // Deliver the remainder rather than the quotient.
    logic negate;       // Negate the magnitude result at the end.
    logic div_zero_s;   // Signed divide by zero: force the saturated value.
    logic zero_result;  // Unused operation code: the result is zero.
  } ctrl_t;

  // Partial remainder and quotient shift register of one division step.
  typedef struct packed {
    logic [DataWidth-1:0] rem;
    logic [DataWidth-1:0] quo;
  } step_t;

  // One restoring division step: shift the next dividend bit into the partial
  // remainder, try to subtract the divisor and shift the outcome into the quotient.
  function automatic step_t div_step(input step_t cur, input logic [DataWidth-1:0] dsr);
    logic [DataWidth:0] trial;
    logic [DataWidth:0] diff;
    step_t              nxt;
    trial = {cur.rem, cur.quo[DataWidth-1]};
    diff  = trial - {1'b0, dsr};
    if (diff[DataWidth]) begin
      nxt.rem = trial[DataWidth-1:0];
      nxt.quo = {cur.quo[DataWidth-2:0], 1'b0};
    end else begin
      nxt.rem = diff[DataWidth-1:0];
      nxt.quo = {cur.quo[DataWidth-2:0], 1'b1};
    end
    return nxt;
  endfunction

endpackage

@@ design/integer_divide_remainder_unit.sv @@
// Pipelined 32-bit signed and unsigned divide and remainder unit.
// The unit accepts one transaction per clock cycle while in_stall_o is low, and
// each result passes through these registers in order, with two quotient bits per
// stage by default: one register stage forms the operand magnitudes,
// 32 / BitsPerStage stages each run BitsPerStage restoring subtract steps, and a
// final output register applies the sign and the special cases. Operation codes
// are 4 signed divide, 5 unsigned divide, 6 signed remainder and 7 unsigned
// remainder; codes 0 to 3 return zero. Quotients truncate toward zero and a signed
// remainder takes the sign of the dividend. A divide by zero returns 0x7FFFFFFF
// when signed and all ones when unsigned, a remainder by zero returns the dividend,
// and the most negative value divided by minus one gives itself as quotient and
// zero as remainder. Every stage holds its own valid bit and moves forward whenever
// the stage after it has room, so a stalled output only backs up the pipeline as
// far as needed, and bubbles are squeezed out.
module integer_divide_remainder_unit #(
  parameter int unsigned BitsPerStage = idru_pkg::DefaultBitsPerStage
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [idru_pkg::OpWidth-1:0]       operation_i,
  input  logic [idru_pkg::DataWidth-1:0]     dividend_i,
  input  logic [idru_pkg::DataWidth-1:0]     divisor_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [idru_pkg::DataWidth-1:0]     result_o
);
  import idru_pkg::*;

  localparam int unsigned NumStages = DataWidth / BitsPerStage;

  // Pipeline registers: entry stage 0 and division stages 1 to NumStages.
  logic                 valid_q [NumStages+1];
  ctrl_t                ctrl_q  [NumStages+1];
  step_t                step_q  [NumStages+1];
  logic [DataWidth-1:0] dsr_q   [NumStages+1];

  // Output register.
  logic                 out_valid_q;
  logic [DataWidth-1:0] result_q;

  // A stage may load when it is empty or when its content moves on.
  logic [NumStages+1:0] load;

  always_comb begin
    load[NumStages+1] = !out_valid_q || !out_stall_i;
    for (int k = NumStages; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  assign in_stall_o = !load[0];

  // Decode the operation and form the operand magnitudes on entry.
  logic                 is_div;
  logic                 is_rem;
  logic                 is_signed;
  logic                 a_neg;
  logic                 b_neg;
  ctrl_t                entry_ctrl;
  logic [DataWidth-1:0] mag_a;
  logic [DataWidth-1:0] mag_b;

  always_comb begin
    is_div    = (operation_i == OpDiv) || (operation_i == OpDivu);
    is_rem    = (operation_i == OpRem) || (operation_i == OpRemu);
    is_signed = (operation_i == OpDiv) || (operation_i == OpRem);
    a_neg     = is_signed && dividend_i[DataWidth-1];
    b_neg     = is_signed && divisor_i[DataWidth-1];
    mag_a     = a_neg ? (DataWidth'(0) - dividend_i) : dividend_i;
    mag_b     = b_neg ? (DataWidth'(0) - divisor_i) : divisor_i;
    entry_ctrl.is_rem      = is_rem;
    entry_ctrl.negate      = is_rem ? a_neg : (a_neg ^ b_neg);
    entry_ctrl.div_zero_s  = (operation_i == OpDiv) && (divisor_i == '0);
    entry_ctrl.zero_result = !(is_div || is_rem);
  end

  // Entry stage: valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (load[0]) begin
      valid_q[0] <= in_valid_i;
    end
  end

  // Entry stage: payload. The dividend magnitude starts in the quotient register
  // and is shifted out into the partial remainder one bit per step.
  always_ff @(posedge clk_i) begin
    if (load[0] && in_valid_i) begin
      ctrl_q[0]     <= entry_ctrl;
      step_q[0].rem <= '0;
      step_q[0].quo <= mag_a;
      dsr_q[0]      <= mag_b;
    end
  end

  // Division stages, each resolving BitsPerStage quotient bits.
  for (genvar k = 1; k <= NumStages; k++) begin : g_stage
    step_t step_d;

    always_comb begin
      step_t cur;
      cur = step_q[k-1];
      for (int b = 0; b < BitsPerStage; b++) begin
        cur = div_step(cur, dsr_q[k-1]);
      end
      step_d = cur;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (load[k]) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (load[k] && valid_q[k-1]) begin
        ctrl_q[k] <= ctrl_q[k-1];
        step_q[k] <= step_d;
        dsr_q[k]  <= dsr_q[k-1];
      end
    end
  end

  // Final selection: quotient or remainder, sign, and the fixed special results.
  logic [DataWidth-1:0] mag_res;
  logic [DataWidth-1:0] result_d;

  always_comb begin
    mag_res = ctrl_q[NumStages].is_rem ? step_q[NumStages].rem : step_q[NumStages].quo;
    if (ctrl_q[NumStages].zero_result) begin
      result_d = '0;
    end else if (ctrl_q[NumStages].div_zero_s) begin
      result_d = DivZeroSigned;
    end else if (ctrl_q[NumStages].negate) begin
      result_d = DataWidth'(0) - mag_res;
    end else begin
      result_d = mag_res;
    end
  end

  // Output register: valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load[NumStages+1]) begin
      out_valid_q <= valid_q[NumStages];
    end
  end

  // Output register: result.
  always_ff @(posedge clk_i) begin
    if (load[NumStages+1] && valid_q[NumStages]) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

@@ design/idru_checker.sv @@
// Port-level checks for the integer divide unit and the bind that attaches them.
module idru_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [idru_pkg::OpWidth-1:0]   operation_i,
  input logic [idru_pkg::DataWidth-1:0] dividend_i,
  input logic [idru_pkg::DataWidth-1:0] divisor_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [idru_pkg::DataWidth-1:0] result_o
);

  // No result is offered in the cycle after the unit is seen in reset.
  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result offered during reset");

  // With no result waiting, every stage can advance, so the input never stalls.
  a_no_stall_when_empty_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled although no result is waiting");

  // A stalled input transaction stays offered and unchanged.
  a_in_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(operation_i) &&
    $stable(dividend_i) && $stable(divisor_i))
    else $error("input transaction changed while stalled");

  // A stalled result transaction stays offered.
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result does not change.
  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_o))
    else $error("result changed while stalled");

endmodule

bind integer_divide_remainder_unit idru_checker u_idru_checker (.*);

@@ verif/integer_divide_remainder_unit_test.sv @@
// Self-checking testbench for the pipelined integer divide and remainder unit.
`timescale 1ns / 100ps

module integer_divide_remainder_unit_test;
  import idru_pkg::*;

  // One divide or remainder request as presented to the unit.
  typedef struct {
    logic [OpWidth-1:0]   op;
    logic [DataWidth-1:0] dividend;
    logic [DataWidth-1:0] divisor;
  } div_request_t;

  // A request that the unit has taken, paired with the result it must return.
  typedef struct {
    div_request_t         req;
    logic [DataWidth-1:0] answer;
  } div_answer_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [OpWidth-1:0]   operation_i = '0;
  logic [DataWidth-1:0] dividend_i  = '0;
  logic [DataWidth-1:0] divisor_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [DataWidth-1:0] result_o;

  div_request_t pending_requests[$];
  div_answer_t  awaited_answers[$];

  int unsigned cycle_count     = 0;
  int unsigned mismatch_count  = 0;
  int unsigned results_checked = 0;
  int unsigned divides_sent    = 0;
  int unsigned remainders_sent = 0;
  int unsigned unused_ops_sent = 0;
  int unsigned zero_divisors   = 0;
  int unsigned overflow_cases  = 0;

  integer_divide_remainder_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .dividend_i  (dividend_i),
    .divisor_i   (divisor_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o)
  );

  // Free-running clock with a 4 ns period.
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Random idling on either side, except in one quiet window where both run flat out.
  function automatic logic take_a_break();
    if (cycle_count >= 300 && cycle_count < 700) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 19;
  endfunction

  // Expected result of one request: quotient or remainder, from operand magnitudes for the signed codes.
  function automatic logic [DataWidth-1:0] predict_result(input logic [OpWidth-1:0]   op,
                                                          input logic [DataWidth-1:0] num,
                                                          input logic [DataWidth-1:0] den);
    logic [DataWidth-1:0] num_mag;
    logic [DataWidth-1:0] den_mag;
    logic [DataWidth-1:0] quo_mag;
    logic [DataWidth-1:0] rem_mag;
    num_mag = num[DataWidth-1] ? (~num + 1'b1) : num;
    den_mag = den[DataWidth-1] ? (~den + 1'b1) : den;
    quo_mag = '0;
    rem_mag = '0;
    if (den != '0) begin
      quo_mag = num_mag / den_mag;
      rem_mag = num_mag % den_mag;
    end
    case (op)
      OpDiv: begin
        if (den == '0) begin
          return DivZeroSigned;
        end
        return (num[DataWidth-1] ^ den[DataWidth-1]) ? (~quo_mag + 1'b1) : quo_mag;
      end
      OpDivu: begin
        return (den == '0) ? DivZeroUnsigned : num / den;
      end
      OpRem: begin
        if (den == '0) begin
          return num;
        end
        return num[DataWidth-1] ? (~rem_mag + 1'b1) : rem_mag;
      end
      OpRemu: begin
        return (den == '0) ? num : num % den;
      end
      default: begin
        return '0;
      end
    endcase
  endfunction

  // Prints one line per failure and keeps count.
  task automatic report_mismatch(input string msg);
    $display("ERROR @ %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_request(input logic [OpWidth-1:0]   op,
                               input logic [DataWidth-1:0] num,
                               input logic [DataWidth-1:0] den);
    div_request_t req;
    req.op       = op;
    req.dividend = num;
    req.divisor  = den;
    pending_requests.push_back(req);
  endtask

  // Operand mix: full random patterns, small values of either sign, values of
  // random width, and the boundary values of both signed and unsigned ranges.
  function automatic logic [DataWidth-1:0] pick_operand();
    int unsigned          kind;
    logic [DataWidth-1:0] val;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      val = $urandom;
    end else if (kind < 65) begin
      val = $urandom_range(0, 40);
      if ($urandom_range(0, 1)) val = ~val + 1'b1;
    end else if (kind < 80) begin
      val = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 1)) val = ~val + 1'b1;
    end else begin
      case ($urandom_range(0, 6))
        0: val = 32'h0000_0000;
        1: val = 32'h0000_0001;
        2: val = 32'hFFFF_FFFF;
        3: val = 32'h8000_0000;
        4: val = 32'h7FFF_FFFF;
        5: val = 32'h0000_0002;
        default: val = 32'hFFFF_FFFE;
      endcase
    end
    return val;
  endfunction

  // Input side: present queued requests, holding each one until it is taken.
  always @(posedge clk_i) begin : drive_requests
    div_request_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        awaited_answers.push_back('{req: '{op: operation_i, dividend: dividend_i,
                                           divisor: divisor_i},
                                    answer: predict_result(operation_i, dividend_i,
                                                           divisor_i)});
        if (operation_i == OpDiv || operation_i == OpDivu) divides_sent++;
        else if (operation_i == OpRem || operation_i == OpRemu) remainders_sent++;
        else unused_ops_sent++;
        if (divisor_i == '0 && operation_i[OpWidth-1]) zero_divisors++;
        if ((operation_i == OpDiv || operation_i == OpRem) &&
            dividend_i == 32'h8000_0000 && divisor_i == 32'hFFFF_FFFF) begin
          overflow_cases++;
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && !take_a_break()) begin
          nxt = pending_requests.pop_front();
          in_valid_i  <= 1'b1;
          operation_i <= nxt.op;
          dividend_i  <= nxt.dividend;
          divisor_i   <= nxt.divisor;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: random back-pressure on the result channel.
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && take_a_break();
  end

  // Compare each delivered result with the oldest outstanding transaction.
  always @(posedge clk_i) begin : check_results
    div_answer_t head;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_answers.size() == 0) begin
        report_mismatch($sformatf("result %h delivered with no transaction outstanding",
                                  result_o));
      end else begin
        head = awaited_answers.pop_front();
        results_checked++;
        if (result_o !== head.answer) begin
          report_mismatch($sformatf("op %0d, %h by %h: result %h, expected %h",
                                    head.req.op, head.req.dividend, head.req.divisor,
                                    result_o, head.answer));
        end
      end
    end
  end

  // Build the stimulus, release reset, then wait for the pipeline to drain.
  initial begin : run_sequence
    logic [OpWidth-1:0] op;
    int unsigned        drain;

    // Unused operation codes all return zero.
    queue_request(3'd0, 32'h1234_5678, 32'h0000_0003);
    queue_request(3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(3'd2, 32'h8000_0000, 32'h0000_0000);
    queue_request(3'd3, 32'h7FFF_FFFF, 32'h0000_0001);
    // Truncation toward zero across all sign combinations.
    queue_request(OpDiv, 32'd7, 32'd2);
    queue_request(OpDiv, 32'hFFFF_FFF9, 32'd2);
    queue_request(OpDiv, 32'd7, 32'hFFFF_FFFE);
    queue_request(OpDiv, 32'hFFFF_FFF9, 32'hFFFF_FFFE);
    queue_request(OpRem, 32'hFFFF_FFF9, 32'd2);
    queue_request(OpRem, 32'd7, 32'hFFFF_FFFE);
    queue_request(OpDivu, 32'hFFFF_FFFF, 32'd1);
    queue_request(OpDivu, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(OpRemu, 32'hFFFF_FFFF, 32'h0000_0010);
    // Division and remainder by zero.
    queue_request(OpDiv, 32'd5, 32'd0);
    queue_request(OpDiv, 32'h8000_0000, 32'd0);
    queue_request(OpDivu, 32'd123, 32'd0);
    queue_request(OpRem, 32'h8000_0001, 32'd0);
    queue_request(OpRemu, 32'hFFFF_FFFF, 32'd0);
    // Most negative value divided by minus one.
    queue_request(OpDiv, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_request(OpRem, 32'h8000_0000, 32'hFFFF_FFFF);
    // Range extremes against each other.
    queue_request(OpDivu, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_request(OpDiv, 32'd0, 32'h7FFF_FFFF);
    queue_request(OpDiv, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(OpRem, 32'h8000_0000, 32'h7FFF_FFFF);

    // Random part: mostly real divide and remainder codes.
    repeat (1350) begin
      if ($urandom_range(0, 99) < 85) op = OpDiv | OpWidth'($urandom_range(0, 3));
      else op = OpWidth'($urandom_range(0, 3));
      queue_request(op, pick_operand(), pick_operand());
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || in_valid_i) @(posedge clk_i);
    drain = 0;
    while (awaited_answers.size() != 0 && drain < 4000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (40) @(posedge clk_i);

    foreach (awaited_answers[i]) begin
      report_mismatch($sformatf("no result for op %0d, %h by %h (expected %h)",
                                awaited_answers[i].req.op, awaited_answers[i].req.dividend,
                                awaited_answers[i].req.divisor, awaited_answers[i].answer));
    end

    $display("Checked %0d results: %0d divides, %0d remainders, %0d unused codes.",
             results_checked, divides_sent, remainders_sent, unused_ops_sent);
    $display("Covered %0d zero divisors and %0d signed overflow transactions.",
             zero_divisors, overflow_cases);
    if (mismatch_count == 0) begin
      $display("integer_divide_remainder_unit_test: PASS");
    end else begin
      $display("integer_divide_remainder_unit_test: FAIL");
    end
    $finish;
  end

  // Watchdog against a hung pipeline.
  initial begin
    #400000;
    $display("integer_divide_remainder_unit_test: FAIL");
    $finish;
  end

endmodule
